### rtl/btpc_pkg.sv
// Shared widths, register indexes and pipeline types for the pressure compensation block.
package btpc_pkg;

    localparam int RAW_W    = 20;
    localparam int RES_W    = 32;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HI  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_P9  = 2'd3;

    // one restoring divide step: remainder, shifting numerator/quotient, divisor magnitude
    typedef struct packed {
        logic [30:0]      rem;
        logic [63:0]      nq;
        logic [30:0]      dv;
        logic             qneg;
        logic             zero;
        logic [RES_W-1:0] tc;
    } div_stage_t;

endpackage

### rtl/btpc_if.sv
// Stream interfaces for raw samples in and compensated results out.
interface btpc_raw_if import btpc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_temperature;
    logic [RAW_W-1:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface btpc_res_if import btpc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] temperature_centi;
    logic [RES_W-1:0]        pressure_q24_8;
    logic                    pressure_valid;

    modport source (output valid, output temperature_centi, output pressure_q24_8,
                    output pressure_valid, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_q24_8,
                    input pressure_valid, output ready);
endinterface

### rtl/baro_temp_press_compensation.sv
// An accepted word passes through every stage to its result on the output register.
// Throughput: one word per cycle unless the output stalls; 11 arithmetic stages, a
// 64-stage restoring divider (one quotient bit per stage) and 6 post-divide stages,
// all advancing together. A stall on the output freezes the whole pipeline; nothing
// is dropped or repeated. Reset clears the coefficient registers and all stage valid bits.
module baro_temp_press_compensation import btpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    btpc_raw_if.sink             raw,
    btpc_res_if.source           comp
);

    localparam int NST = 11 + DIV_STEPS + 6;

    logic [47:0] tc_reg;
    logic [63:0] pcl_reg;
    logic [63:0] pch_reg;
    logic [15:0] p9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg  <= '0;
            pcl_reg <= '0;
            pch_reg <= '0;
            p9_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEMP:     tc_reg  <= cfg_wdata[47:0];
                CFG_PRESS_LO: pcl_reg <= cfg_wdata;
                CFG_PRESS_HI: pch_reg <= cfg_wdata;
                CFG_PRESS_P9: p9_reg  <= cfg_wdata[15:0];
                default:      tc_reg  <= tc_reg;
            endcase
        end
    end

    logic [15:0]        t1;
    logic signed [15:0] t2, t3, p2, p4, p5, p6;
    logic [15:0]        p1, p3u, p7, p8, p9;
    assign t1  = tc_reg[15:0];
    assign t2  = $signed(tc_reg[31:16]);
    assign t3  = $signed(tc_reg[47:32]);
    assign p1  = pcl_reg[15:0];
    assign p2  = $signed(pcl_reg[31:16]);
    assign p3u = pcl_reg[47:32];
    assign p4  = $signed(pcl_reg[63:48]);
    assign p5  = $signed(pch_reg[15:0]);
    assign p6  = $signed(pch_reg[31:16]);
    assign p7  = pch_reg[47:32];
    assign p8  = pch_reg[63:48];
    assign p9  = p9_reg;

    logic signed [15:0] p3;
    assign p3 = $signed(p3u);

    // pipeline control
    logic [NST-1:0] vld_reg;
    logic           adv;
    assign adv       = !vld_reg[NST-1] || comp.ready;
    assign raw.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], raw.valid};
    end

    // S1: temperature differences and first products
    logic signed [18:0] d1;
    logic signed [16:0] d2;
    logic signed [34:0] m1;
    logic signed [33:0] dd;
    assign d1 = $signed({2'b00, raw.raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
    assign d2 = $signed({1'b0, raw.raw_temperature[19:4]}) - $signed({1'b0, t1});
    assign m1 = d1 * t2;
    assign dd = d2 * d2;

    logic [31:0] s1_m1_reg, s1_dd_reg;
    logic [19:0] s1_rp_reg;

    // S2
    logic signed [35:0] m3;
    assign m3 = $signed(s1_dd_reg[31:12]) * t3;
    logic [20:0] s2_v1_reg;
    logic [31:0] s2_m3_reg;
    logic [19:0] s2_rp_reg;

    // S3: fine temperature
    logic [21:0] tf;
    assign tf = {s2_v1_reg[20], s2_v1_reg} + {{4{s2_m3_reg[31]}}, s2_m3_reg[31:14]};
    logic [21:0] s3_tf_reg;
    logic [19:0] s3_rp_reg;

    // S4
    logic signed [22:0] av;
    logic signed [45:0] aa;
    logic signed [38:0] ap5, ap2;
    logic signed [31:0] tf5;
    logic [20:0]        pn;
    assign av  = $signed({s3_tf_reg[21], s3_tf_reg}) - 23'sd128000;
    assign aa  = av * av;
    assign ap5 = av * p5;
    assign ap2 = av * p2;
    assign tf5 = $signed({{10{s3_tf_reg[21]}}, s3_tf_reg}) * 32'sd5 + 32'sd128;
    assign pn  = 21'd1048576 - {1'b0, s3_rp_reg};
    logic [41:0] s4_aa_reg;
    logic [38:0] s4_ap5_reg, s4_ap2_reg;
    logic [31:0] s4_tc_reg;
    logic [20:0] s4_pn_reg;

    // S5: a*a split in halves against P6 and P3
    logic signed [37:0] l6, h6, l3, h3;
    assign l6 = $signed({1'b0, s4_aa_reg[20:0]}) * p6;
    assign h6 = $signed({1'b0, s4_aa_reg[41:21]}) * p6;
    assign l3 = $signed({1'b0, s4_aa_reg[20:0]}) * p3;
    assign h3 = $signed({1'b0, s4_aa_reg[41:21]}) * p3;
    logic [37:0] s5_l6_reg, s5_h6_reg, s5_l3_reg, s5_h3_reg;
    logic [38:0] s5_ap5_reg, s5_ap2_reg;
    logic [31:0] s5_tc_reg;
    logic [20:0] s5_pn_reg;

    // S6
    logic [63:0] aap6, aap3;
    assign aap6 = ({{26{s5_h6_reg[37]}}, s5_h6_reg} << 21) + {{26{s5_l6_reg[37]}}, s5_l6_reg};
    assign aap3 = ({{26{s5_h3_reg[37]}}, s5_h3_reg} << 21) + {{26{s5_l3_reg[37]}}, s5_l3_reg};
    logic [63:0] s6_aap6_reg, s6_aap3_reg;
    logic [38:0] s6_ap5_reg, s6_ap2_reg;
    logic [31:0] s6_tc_reg;
    logic [20:0] s6_pn_reg;

    // S7: b term and divisor pre-product
    logic [63:0] bv, a2, xv;
    assign bv = s6_aap6_reg + ({{25{s6_ap5_reg[38]}}, s6_ap5_reg} << 17)
              + ({{48{p4[15]}}, p4} << 35);
    assign a2 = {{8{s6_aap3_reg[63]}}, s6_aap3_reg[63:8]}
              + ({{25{s6_ap2_reg[38]}}, s6_ap2_reg} << 12);
    assign xv = 64'h0000_8000_0000_0000 + a2;
    logic [63:0] s7_b_reg, s7_x_reg;
    logic [31:0] s7_tc_reg;
    logic [20:0] s7_pn_reg;

    // S8
    logic [47:0] xl, xh;
    logic [63:0] tv;
    assign xl = s7_x_reg[31:0] * p1;
    assign xh = s7_x_reg[63:32] * p1;
    assign tv = {12'd0, s7_pn_reg, 31'd0} - s7_b_reg;
    logic [47:0] s8_xl_reg;
    logic [31:0] s8_xh_reg;
    logic [63:0] s8_t_reg;
    logic [31:0] s8_tc_reg;

    // S9
    logic [63:0] xd;
    logic [43:0] tl, th;
    assign xd = {16'd0, s8_xl_reg} + {s8_xh_reg, 32'd0};
    assign tl = s8_t_reg[31:0] * 12'd3125;
    assign th = s8_t_reg[63:32] * 12'd3125;
    logic [30:0] s9_dv_reg;
    logic [43:0] s9_tl_reg;
    logic [31:0] s9_th_reg;
    logic [31:0] s9_tc_reg;

    // S10: numerator and divisor magnitude
    logic [63:0] num;
    assign num = {20'd0, s9_tl_reg} + {s9_th_reg, 32'd0};
    logic [63:0] s10_num_reg;
    logic [30:0] s10_dabs_reg;
    logic        s10_dneg_reg, s10_zero_reg;
    logic [31:0] s10_tc_reg;

    // S11 feeds the divider
    div_stage_t ds_reg [0:DIV_STEPS];
    div_stage_t ds_in;
    always_comb
    begin
        ds_in.rem  = '0;
        ds_in.nq   = s10_num_reg[63] ? 64'd0 - s10_num_reg : s10_num_reg;
        ds_in.dv   = s10_dabs_reg;
        ds_in.qneg = s10_num_reg[63] ^ s10_dneg_reg;
        ds_in.zero = s10_zero_reg;
        ds_in.tc   = s10_tc_reg;
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_div
            logic [31:0] r2, rn;
            logic        ge;
            div_stage_t  nx;
            assign r2 = {ds_reg[k].rem, ds_reg[k].nq[63]};
            assign ge = r2 >= {1'b0, ds_reg[k].dv};
            assign rn = ge ? r2 - {1'b0, ds_reg[k].dv} : r2;
            always_comb
            begin
                nx     = ds_reg[k];
                nx.rem = rn[30:0];
                nx.nq  = {ds_reg[k].nq[62:0], ge};
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                    ds_reg[k+1] <= nx;
            end
        end
    endgenerate

    // P1: signed quotient
    logic [63:0] qv;
    assign qv = ds_reg[DIV_STEPS].qneg ? 64'd0 - ds_reg[DIV_STEPS].nq : ds_reg[DIV_STEPS].nq;
    logic [63:0] q1_p_reg;
    logic        q1_z_reg;
    logic [31:0] q1_tc_reg;

    // P2: square of p>>13 and P8 product, low 64 bits by partial products
    logic [63:0] ps, ll, lh;
    logic [47:0] dl, dh;
    assign ps = {{13{q1_p_reg[63]}}, q1_p_reg[63:13]};
    assign ll = ps[31:0] * ps[31:0];
    assign lh = ps[31:0] * ps[63:32];
    assign dl = q1_p_reg[31:0] * p8;
    assign dh = q1_p_reg[63:32] * p8;
    logic [63:0] q2_ll_reg, q2_p_reg;
    logic [30:0] q2_lh_reg;
    logic [47:0] q2_dl_reg;
    logic [31:0] q2_dh_reg;
    logic        q2_z_reg;
    logic [31:0] q2_tc_reg;

    // P3
    logic [63:0] sq, pd;
    assign sq = q2_ll_reg + {q2_lh_reg, 33'd0};
    assign pd = {16'd0, q2_dl_reg} + {q2_dh_reg, 32'd0}
              - (p8[15] ? {q2_p_reg[47:0], 16'd0} : 64'd0);
    logic [63:0] q3_sq_reg, q3_ds_reg, q3_p_reg;
    logic        q3_z_reg;
    logic [31:0] q3_tc_reg;

    // P4
    logic [47:0] cl, ch;
    assign cl = q3_sq_reg[31:0] * p9;
    assign ch = q3_sq_reg[63:32] * p9;
    logic [47:0] q4_cl_reg;
    logic [31:0] q4_ch_reg;
    logic [63:0] q4_sq_reg, q4_ds_reg, q4_p_reg;
    logic        q4_z_reg;
    logic [31:0] q4_tc_reg;

    // P5
    logic [63:0] cv, sum;
    assign cv  = {16'd0, q4_cl_reg} + {q4_ch_reg, 32'd0}
               - (p9[15] ? {q4_sq_reg[47:0], 16'd0} : 64'd0);
    assign sum = q4_p_reg + {{25{cv[63]}}, cv[63:25]} + q4_ds_reg;
    logic [63:0] q5_sum_reg;
    logic        q5_z_reg;
    logic [31:0] q5_tc_reg;

    // P6: output register
    logic [63:0] res;
    assign res = {{8{q5_sum_reg[63]}}, q5_sum_reg[63:8]} + {{44{p7[15]}}, p7, 4'd0};
    logic [31:0] o_tc_reg, o_p_reg;
    logic        o_pv_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_m1_reg    <= m1[31:0];
            s1_dd_reg    <= dd[31:0];
            s1_rp_reg    <= raw.raw_pressure;

            s2_v1_reg    <= s1_m1_reg[31:11];
            s2_m3_reg    <= m3[31:0];
            s2_rp_reg    <= s1_rp_reg;

            s3_tf_reg    <= tf;
            s3_rp_reg    <= s2_rp_reg;

            s4_aa_reg    <= aa[41:0];
            s4_ap5_reg   <= ap5;
            s4_ap2_reg   <= ap2;
            s4_tc_reg    <= {{8{tf5[31]}}, tf5[31:8]};
            s4_pn_reg    <= pn;

            s5_l6_reg    <= l6;
            s5_h6_reg    <= h6;
            s5_l3_reg    <= l3;
            s5_h3_reg    <= h3;
            s5_ap5_reg   <= s4_ap5_reg;
            s5_ap2_reg   <= s4_ap2_reg;
            s5_tc_reg    <= s4_tc_reg;
            s5_pn_reg    <= s4_pn_reg;

            s6_aap6_reg  <= aap6;
            s6_aap3_reg  <= aap3;
            s6_ap5_reg   <= s5_ap5_reg;
            s6_ap2_reg   <= s5_ap2_reg;
            s6_tc_reg    <= s5_tc_reg;
            s6_pn_reg    <= s5_pn_reg;

            s7_b_reg     <= bv;
            s7_x_reg     <= xv;
            s7_tc_reg    <= s6_tc_reg;
            s7_pn_reg    <= s6_pn_reg;

            s8_xl_reg    <= xl;
            s8_xh_reg    <= xh[31:0];
            s8_t_reg     <= tv;
            s8_tc_reg    <= s7_tc_reg;

            s9_dv_reg    <= xd[63:33];
            s9_tl_reg    <= tl;
            s9_th_reg    <= th[31:0];
            s9_tc_reg    <= s8_tc_reg;

            s10_num_reg  <= num;
            s10_dabs_reg <= s9_dv_reg[30] ? 31'd0 - s9_dv_reg : s9_dv_reg;
            s10_dneg_reg <= s9_dv_reg[30];
            s10_zero_reg <= s9_dv_reg == 31'd0;
            s10_tc_reg   <= s9_tc_reg;

            ds_reg[0]    <= ds_in;

            q1_p_reg     <= qv;
            q1_z_reg     <= ds_reg[DIV_STEPS].zero;
            q1_tc_reg    <= ds_reg[DIV_STEPS].tc;

            q2_ll_reg    <= ll;
            q2_lh_reg    <= lh[30:0];
            q2_dl_reg    <= dl;
            q2_dh_reg    <= dh[31:0];
            q2_p_reg     <= q1_p_reg;
            q2_z_reg     <= q1_z_reg;
            q2_tc_reg    <= q1_tc_reg;

            q3_sq_reg    <= sq;
            q3_ds_reg    <= {{19{pd[63]}}, pd[63:19]};
            q3_p_reg     <= q2_p_reg;
            q3_z_reg     <= q2_z_reg;
            q3_tc_reg    <= q2_tc_reg;

            q4_cl_reg    <= cl;
            q4_ch_reg    <= ch[31:0];
            q4_sq_reg    <= q3_sq_reg;
            q4_ds_reg    <= q3_ds_reg;
            q4_p_reg     <= q3_p_reg;
            q4_z_reg     <= q3_z_reg;
            q4_tc_reg    <= q3_tc_reg;

            q5_sum_reg   <= sum;
            q5_z_reg     <= q4_z_reg;
            q5_tc_reg    <= q4_tc_reg;

            o_tc_reg     <= q5_tc_reg;
            o_p_reg      <= q5_z_reg ? 32'd0 : res[31:0];
            o_pv_reg     <= !q5_z_reg;
        end
    end

    assign comp.valid             = vld_reg[NST-1];
    assign comp.temperature_centi = $signed(o_tc_reg);
    assign comp.pressure_q24_8    = o_p_reg;
    assign comp.pressure_valid    = o_pv_reg;

endmodule
